[src/osat_pkg.sv]
package osat_pkg;

    // Table geometry
    localparam int CAPACITY = 8;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CMD_W    = 3;
    localparam int ADDR_W   = 32;
    localparam int PORT_W   = 16;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_ADD    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_UPDATE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_FIND   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_FIRST  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_NEXT   = 3'd5;

    // Scan token handed from cell to cell
    typedef struct packed {
        logic              live;  // token present at this cell
        logic              hit;   // a match was seen upstream
        logic              grab;  // upstream neighbor asks this cell for its entry
        logic              ok;    // result entry captured
        logic [ADDR_W-1:0] addr;
        logic [PORT_W-1:0] port;
    } tok_t;

    // Request broadcast to every cell
    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [ADDR_W-1:0] key;
        logic [PORT_W-1:0] port;
    } ctl_t;

endpackage

[src/osat_cell.sv]
module osat_cell
    import osat_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  ctl_t              ctl,
    input  logic              valid,
    input  logic              add_wr,
    input  tok_t              tok_in,
    input  logic [ADDR_W-1:0] nbr_addr,
    input  logic [PORT_W-1:0] nbr_port,
    output tok_t              tok_out,
    output logic [ADDR_W-1:0] entry_addr,
    output logic [PORT_W-1:0] entry_port
);

    logic [ADDR_W-1:0] addr_reg;
    logic [PORT_W-1:0] port_reg;
    tok_t              tok_reg;
    tok_t              tok_next;
    logic              uses_key;
    logic              match;
    logic              first;
    logic              take;
    logic              shift;

    // Compare this entry against the key while the token sits here
    always_comb
    begin
        uses_key = ctl.cmd inside {CMD_ADD, CMD_DELETE, CMD_UPDATE, CMD_FIND, CMD_NEXT};
        match    = tok_in.live && valid && uses_key && (addr_reg == ctl.key);
        first    = match && !tok_in.hit;
        take     = tok_in.live && valid && tok_in.grab
                   && ((ctl.cmd == CMD_NEXT) || (ctl.cmd == CMD_FIRST));
        shift    = tok_in.live && valid && (ctl.cmd == CMD_DELETE)
                   && (tok_in.hit || match);
    end

    // Build the token for the next cell
    always_comb
    begin
        tok_next      = tok_in;
        tok_next.hit  = tok_in.hit || match;
        tok_next.grab = first && (ctl.cmd == CMD_NEXT);
        if ((first && (ctl.cmd == CMD_FIND)) || take)
        begin
            tok_next.ok   = 1'b1;
            tok_next.addr = addr_reg;
            tok_next.port = port_reg;
        end
    end

    // Advance the token one cell per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    // Append, pull down from the neighbor on delete, or rewrite the port
    always_ff @(posedge clk)
    begin
        if (add_wr)
        begin
            addr_reg <= ctl.key;
            port_reg <= ctl.port;
        end
        else if (shift)
        begin
            addr_reg <= nbr_addr;
            port_reg <= nbr_port;
        end
        else if (first && (ctl.cmd == CMD_UPDATE))
        begin
            port_reg <= ctl.port;
        end
    end

    assign tok_out    = tok_reg;
    assign entry_addr = addr_reg;
    assign entry_port = port_reg;

endmodule

[src/ordered_server_address_table.sv]
// Channel   Handshake        Fields
// request   start / busy     command, key_address, port_value
// result    done (strobe)    failed, found_address, found_port
//
// From acceptance, a scan token is registered at the head of the row, walks the
// row of CAPACITY cells, one cell per clock, and when it leaves the row the count
// is committed and the result registered. busy is high from the cycle after
// acceptance until the result cycle, so the next request is taken at the earliest
// at the edge that ends the strobe. Reset clears the count and the control state;
// entries hold garbage until written. The result is shown for one cycle and
// cannot be held off.
module ordered_server_address_table
    import osat_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [CMD_W-1:0]  command,
    input  logic [ADDR_W-1:0] key_address,
    input  logic [PORT_W-1:0] port_value,
    output logic              done,
    output logic              failed,
    output logic [ADDR_W-1:0] found_address,
    output logic [PORT_W-1:0] found_port
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    logic              state_reg;
    logic              state_next;
    ctl_t              ctl_reg;
    ctl_t              ctl_next;
    tok_t              inject_reg;
    tok_t              inject_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              done_reg;
    logic              done_next;
    logic              failed_reg;
    logic              failed_next;
    logic [ADDR_W-1:0] faddr_reg;
    logic [ADDR_W-1:0] faddr_next;
    logic [PORT_W-1:0] fport_reg;
    logic [PORT_W-1:0] fport_next;

    logic              accept;
    logic              finish;
    logic              add_commit;
    tok_t              tail;
    tok_t              tok_chain [CAPACITY+1];
    logic [ADDR_W-1:0] cell_addr [CAPACITY+1];
    logic [PORT_W-1:0] cell_port [CAPACITY+1];
    logic [CAPACITY-1:0] valid_vec;
    logic [CAPACITY-1:0] wr_vec;

    assign accept = start && (state_reg == S_IDLE);
    assign tail   = tok_chain[CAPACITY];
    assign finish = (state_reg == S_SCAN) && tail.live;

    assign tok_chain[0] = inject_reg;
    assign cell_addr[CAPACITY] = '0;
    assign cell_port[CAPACITY] = '0;

    // Append goes to the slot just past the last entry
    assign add_commit = finish && (ctl_reg.cmd == CMD_ADD) && !tail.hit
                        && (count_reg < CNT_W'(CAPACITY));

    // Row of cells
    for (genvar k = 0; k < CAPACITY; k++)
    begin : g_cell
        assign valid_vec[k] = count_reg > CNT_W'(k);
        assign wr_vec[k]    = add_commit && (count_reg == CNT_W'(k));

        osat_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl_reg),
            .valid      (valid_vec[k]),
            .add_wr     (wr_vec[k]),
            .tok_in     (tok_chain[k]),
            .nbr_addr   (cell_addr[k+1]),
            .nbr_port   (cell_port[k+1]),
            .tok_out    (tok_chain[k+1]),
            .entry_addr (cell_addr[k]),
            .entry_port (cell_port[k])
        );
    end

    // Sequencer: take a request, launch the token, commit when it leaves the row
    always_comb
    begin
        state_next  = state_reg;
        ctl_next    = ctl_reg;
        inject_next = '0;
        count_next  = count_reg;
        done_next   = 1'b0;
        failed_next = 1'b1;
        faddr_next  = '0;
        fport_next  = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    ctl_next.cmd     = command;
                    ctl_next.key     = key_address;
                    ctl_next.port    = port_value;
                    inject_next.live = 1'b1;
                    inject_next.grab = (command == CMD_FIRST);
                    state_next       = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (finish)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                    case (ctl_reg.cmd)
                        CMD_ADD:
                        begin
                            failed_next = !add_commit;
                            if (add_commit)
                            begin
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        CMD_DELETE:
                        begin
                            failed_next = !tail.hit;
                            if (tail.hit)
                            begin
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        CMD_UPDATE:
                        begin
                            failed_next = !tail.hit;
                        end
                        CMD_FIND, CMD_FIRST, CMD_NEXT:
                        begin
                            failed_next = !tail.ok;
                            if (tail.ok)
                            begin
                                faddr_next = tail.addr;
                                fport_next = tail.port;
                            end
                        end
                        default:
                        begin
                            failed_next = 1'b1;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            inject_reg <= '0;
            count_reg  <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            inject_reg <= inject_next;
            count_reg  <= count_next;
            done_reg   <= done_next;
        end
    end

    // Request and result payload
    always_ff @(posedge clk)
    begin
        ctl_reg    <= ctl_next;
        failed_reg <= failed_next;
        faddr_reg  <= faddr_next;
        fport_reg  <= fport_next;
    end

    assign busy          = (state_reg == S_SCAN);
    assign done          = done_reg;
    assign failed        = failed_reg;
    assign found_address = faddr_reg;
    assign found_port    = fport_reg;

endmodule

[sim/tb_top.sv]
module tb_top
    import osat_pkg::*;
();

    localparam int CYCLE_LIMIT  = 300000;
    localparam int RANDOM_COUNT = 1000;
    localparam int QUIET_TAIL   = 150;

    // Codes the block does not define
    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

    typedef struct {
        logic              failed;
        logic [ADDR_W-1:0] address;
        logic [PORT_W-1:0] port;
    } answer_t;

    // Table shadow: tracks contents and queues the answer each request should produce
    class address_table_book;
        logic [ADDR_W-1:0] addr_row[CAPACITY];
        logic [PORT_W-1:0] port_row[CAPACITY];
        int                count;
        answer_t           answers[$];
        int                mismatches;

        function new();
            count      = 0;
            mismatches = 0;
        endfunction

        // Return slot of key, or count when absent
        function int slot_of(logic [ADDR_W-1:0] key);
            for (int k = 0; k < count; k++)
                if (addr_row[k] == key)
                    return k;
            return count;
        endfunction

        // Apply one accepted request and queue its answer
        function void note_request(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] key,
                                   logic [PORT_W-1:0] port);
            answer_t a;
            int      pos;
            a.failed  = 1'b1;
            a.address = '0;
            a.port    = '0;
            pos       = slot_of(key);
            case (cmd)
                CMD_ADD:
                    if (count < CAPACITY && pos == count)
                    begin
                        addr_row[count] = key;
                        port_row[count] = port;
                        count++;
                        a.failed = 1'b0;
                    end
                CMD_DELETE:
                    if (pos < count)
                    begin
                        for (int k = pos; k + 1 < count; k++)
                        begin
                            addr_row[k] = addr_row[k + 1];
                            port_row[k] = port_row[k + 1];
                        end
                        count--;
                        a.failed = 1'b0;
                    end
                CMD_UPDATE:
                    if (pos < count)
                    begin
                        port_row[pos] = port;
                        a.failed      = 1'b0;
                    end
                CMD_FIND:
                    if (pos < count)
                    begin
                        a.address = addr_row[pos];
                        a.port    = port_row[pos];
                        a.failed  = 1'b0;
                    end
                CMD_FIRST:
                    if (count > 0)
                    begin
                        a.address = addr_row[0];
                        a.port    = port_row[0];
                        a.failed  = 1'b0;
                    end
                CMD_NEXT:
                    if (pos + 1 < count)
                    begin
                        a.address = addr_row[pos + 1];
                        a.port    = port_row[pos + 1];
                        a.failed  = 1'b0;
                    end
                default: ;
            endcase
            answers.insert(answers.size(), a);
        endfunction

        // Print one mismatch line and count it
        task flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
            mismatches++;
            $display("MISMATCH %s: got %h expected %h", what, got, want);
        endtask

        // Compare one strobed result with the oldest queued answer
        task check_result(logic f, logic [ADDR_W-1:0] addr, logic [PORT_W-1:0] port);
            answer_t a;
            if (answers.size() == 0)
            begin
                flag_mismatch("unexpected result", 64'({f, addr, port}), '0);
                return;
            end
            a = answers.pop_front();
            if (f !== a.failed)
                flag_mismatch("failed", 64'(f), 64'(a.failed));
            if (addr !== a.address)
                flag_mismatch("found_address", 64'(addr), 64'(a.address));
            if (port !== a.port)
                flag_mismatch("found_port", 64'(port), 64'(a.port));
        endtask
    endclass

    logic              clk = 1'b0;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [CMD_W-1:0]  command;
    logic [ADDR_W-1:0] key_address;
    logic [PORT_W-1:0] port_value;
    logic              done;
    logic              failed;
    logic [ADDR_W-1:0] found_address;
    logic [PORT_W-1:0] found_port;

    address_table_book book = new();
    logic [ADDR_W-1:0] key_pool[10];
    int                cycles = 0;

    ordered_server_address_table uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .command       (command),
        .key_address   (key_address),
        .port_value    (port_value),
        .done          (done),
        .failed        (failed),
        .found_address (found_address),
        .found_port    (found_port)
    );

    always #2 clk = ~clk;

    // Stop a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("ordered_server_address_table regression: fail");
            $finish;
        end
    end

    // Check every strobed result
    always @(posedge clk)
    begin
        if (rst_n && done)
            book.check_result(failed, found_address, found_port);
    end

    // Present one request, optionally after an idle burst, and hold until accepted
    task send_request(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] key,
                      logic [PORT_W-1:0] port, int gap);
        @(negedge clk);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start       <= 1'b1;
        command     <= cmd;
        key_address <= key;
        port_value  <= port;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        book.note_request(cmd, key, port);
    endtask

    // Drop start and hold until every queued answer has arrived
    task drain;
        @(negedge clk);
        start <= 1'b0;
        while (book.answers.size() != 0)
            @(negedge clk);
    endtask

    function void refresh_pool();
        foreach (key_pool[k])
            case ($urandom_range(0, 3))
                0:       key_pool[k] = $urandom_range(0, 15);
                1:       key_pool[k] = 32'hFFFF_FFF0 | $urandom_range(0, 15);
                default: key_pool[k] = $urandom;
            endcase
    endfunction

    // Favor keys already in the table so hits dominate
    function logic [ADDR_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50 && book.count > 0)
            return book.addr_row[$urandom_range(0, book.count - 1)];
        if (r < 90)
            return key_pool[$urandom_range(0, 9)];
        return $urandom;
    endfunction

    function logic [CMD_W-1:0] pick_command(int mode);
        int r;
        r = $urandom_range(0, 99);
        if (r < 4)
            return ($urandom_range(0, 1) == 0) ? CMD_SPARE_LO : CMD_SPARE_HI;
        case (mode)
            0:       if (r < 45) return CMD_ADD;
                     else if (r < 52) return CMD_DELETE;
            2:       if (r < 15) return CMD_ADD;
                     else if (r < 45) return CMD_DELETE;
            default: if (r < 28) return CMD_ADD;
                     else if (r < 42) return CMD_DELETE;
        endcase
        r = $urandom_range(0, 99);
        if (r < 20)
            return CMD_UPDATE;
        if (r < 50)
            return CMD_FIND;
        if (r < 65)
            return CMD_FIRST;
        return CMD_NEXT;
    endfunction

    initial
    begin
        int mode;
        int gap;
        bit quiet;
        rst_n       = 1'b0;
        start       = 1'b0;
        command     = CMD_ADD;
        key_address = '0;
        port_value  = '0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty table, fill, full, lookups, walk ends, deletes, unknown codes
        send_request(CMD_FIRST,    32'h0000_0000, 16'h0000, 0);
        send_request(CMD_NEXT,     32'h0000_0000, 16'h0000, 0);
        send_request(CMD_FIND,     32'h0000_0000, 16'h0000, 0);
        send_request(CMD_DELETE,   32'h0000_0000, 16'h0000, 0);
        send_request(CMD_UPDATE,   32'h0000_0000, 16'hFFFF, 0);
        send_request(CMD_ADD,      32'h0000_0000, 16'h0000, 0);
        send_request(CMD_ADD,      32'hFFFF_FFFF, 16'hFFFF, 0);
        send_request(CMD_ADD,      32'h0000_0000, 16'h1234, 0);
        send_request(CMD_ADD,      32'h8000_0001, 16'h8000, 0);
        send_request(CMD_ADD,      32'h7FFF_FFFE, 16'h7FFF, 0);
        send_request(CMD_ADD,      32'h1234_5678, 16'h0001, 0);
        send_request(CMD_ADD,      32'hA5A5_5A5A, 16'hA5A5, 0);
        send_request(CMD_ADD,      32'h0000_0100, 16'h5A5A, 0);
        send_request(CMD_ADD,      32'hFFFF_FFFE, 16'hFFFE, 0);
        send_request(CMD_ADD,      32'h5555_AAAA, 16'h0F0F, 0);
        send_request(CMD_UPDATE,   32'hFFFF_FFFF, 16'h8001, 0);
        send_request(CMD_FIND,     32'hFFFF_FFFF, 16'h0000, 0);
        send_request(CMD_NEXT,     32'h0000_0000, 16'h0000, 0);
        send_request(CMD_NEXT,     32'hFFFF_FFFE, 16'h0000, 0);
        send_request(CMD_NEXT,     32'h5555_AAAA, 16'h0000, 0);
        send_request(CMD_DELETE,   32'h8000_0001, 16'h0000, 0);
        send_request(CMD_DELETE,   32'h0000_0000, 16'h0000, 0);
        send_request(CMD_DELETE,   32'hFFFF_FFFE, 16'h0000, 0);
        send_request(CMD_FIRST,    32'h0000_0000, 16'h0000, 0);
        send_request(CMD_SPARE_LO, 32'hFFFF_FFFF, 16'hFFFF, 0);
        send_request(CMD_SPARE_HI, 32'h0000_0000, 16'h0000, 0);
        drain();

        // Random: mix mostly over a small key pool, with some undefined codes, switching fill and drain modes
        refresh_pool();
        mode  = 1;
        quiet = 1'b0;
        for (int n = 0; n < RANDOM_COUNT; n++)
        begin
            if (n % 250 == 0)
                refresh_pool();
            if (n % 100 == 0)
                mode = $urandom_range(0, 2);
            if (n % 40 == 0)
                quiet = ($urandom_range(0, 2) == 0);
            if (n % 300 == 299)
                drain();
            gap = 0;
            if (n < RANDOM_COUNT - QUIET_TAIL && !quiet && $urandom_range(0, 3) == 0)
                gap = $urandom_range(1, 3);
            send_request(pick_command(mode), pick_key(),
                         PORT_W'($urandom_range(0, 65535)), gap);
        end

        // Wait out the last results
        @(negedge clk);
        start <= 1'b0;
        while (book.answers.size() != 0)
            @(posedge clk);
        repeat (CAPACITY + 6) @(posedge clk);

        if (book.mismatches == 0 && book.answers.size() == 0)
            $display("ordered_server_address_table regression: pass");
        else
            $display("ordered_server_address_table regression: fail");
        $finish;
    end

endmodule
